@@ hw/rtl/lru_key_value_cache_top_assert.svh @@
// Assertion macros for the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LKV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lkv_pkg.sv @@
// Types and constants for the LRU key-value cache.
`default_nettype none
package lkv_pkg;
	localparam int DATA_W          = 32;
	localparam int LIMIT_W         = 5;
	localparam int ENTRIES_DEFAULT = 16;
	localparam int ADDR_W          = 3;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// Register index, taken from paddr above the byte offset.
	localparam logic REG_ENTRY_LIMIT = 1'b0;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic                     hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;
endpackage
`default_nettype wire

@@ hw/rtl/lru_key_value_cache_top.sv @@
// Top level of the fully associative LRU key-value cache.
//
//  channel   beat                         handshake
//  request   req (cmd, lookup_key, value) start high while busy low
//  response  rsp (hit, read_value)        done high for one cycle
//  config    entry_limit at byte addr 0   APB write, pready tied high
//
// One request per cycle; busy never rises. A request is registered in req_s1,
// then compared combinationally against all slots; a get's response is
// registered into done and rsp from that comparison. Rank and slot state
// update on the same edge that registers the response, so back-to-back
// requests see each other's effects. Reset empties the store at once.
// The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none
module lru_key_value_cache_top #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire lkv_pkg::req_t              req,
	output      logic                       done,
	output      lkv_pkg::rsp_t              rsp,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lkv_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output      logic [31:0]                prdata,
	output      logic                       pready
);
	import lkv_pkg::*;

`include "lru_key_value_cache_top_assert.svh"

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	// config
	logic [LIMIT_W-1:0] limit_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_LIMIT);
	assign prdata = (paddr[2] == REG_ENTRY_LIMIT) ? {{(32-LIMIT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// input register
	logic valid_s1;
	req_t req_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	// slot state
	logic [ENTRIES-1:0]             valid_q;
	logic [IDX_W-1:0]               rank_q [ENTRIES];
	logic signed [DATA_W-1:0]       key_q  [ENTRIES];
	logic signed [DATA_W-1:0]       val_q  [ENTRIES];
	logic [CNT_W-1:0]               occ_q;

	logic [ENTRIES-1:0]             match;
	logic                           hit_any;
	logic [IDX_W-1:0]               hit_rank;
	logic signed [DATA_W-1:0]       hit_val;
	logic [CMP_W-1:0]               eff_limit;
	logic                           full;
	logic [IDX_W-1:0]               last_rank;
	logic [IDX_W-1:0]               free_idx;
	logic [IDX_W-1:0]               victim_idx;
	logic [IDX_W-1:0]               ins_idx;
	logic                           do_insert;
	logic [ENTRIES-1:0]             valid_d;
	logic [IDX_W-1:0]               rank_d [ENTRIES];
	logic [CNT_W-1:0]               occ_d;
	logic [ENTRIES-1:0]             key_we;
	logic [ENTRIES-1:0]             val_we;

	always_comb begin
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req_s1.lookup_key);
			hit_rank = hit_rank | (match[i] ? rank_q[i] : '0);
			hit_val  = hit_val | (match[i] ? val_q[i] : '0);
		end
		hit_any = |match;
	end

	always_comb begin
		if (limit_q == '0) begin
			eff_limit = CMP_W'(1);
		end else if (CMP_W'(limit_q) > CMP_W'(ENTRIES)) begin
			eff_limit = CMP_W'(ENTRIES);
		end else begin
			eff_limit = CMP_W'(limit_q);
		end
		full      = CMP_W'(occ_q) >= eff_limit;
		last_rank = IDX_W'(occ_q - CNT_W'(1));
		free_idx   = '0;
		victim_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
			if (valid_q[i] && (rank_q[i] == last_rank)) begin
				victim_idx = IDX_W'(i);
			end
		end
		ins_idx = full ? victim_idx : free_idx;
	end

	always_comb begin
		do_insert = valid_s1 && (req_s1.cmd == CMD_SET) && !hit_any;
		valid_d   = valid_q;
		occ_d     = occ_q;
		key_we    = '0;
		val_we    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (valid_s1 && hit_any) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (match[i]) begin
					rank_d[i] = '0;
					val_we[i] = (req_s1.cmd == CMD_SET);
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + IDX_W'(1);
				end
			end
		end else if (do_insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == ins_idx) begin
					rank_d[i]  = '0;
					valid_d[i] = 1'b1;
					key_we[i]  = 1'b1;
					val_we[i]  = 1'b1;
				end else if (valid_q[i]) begin
					rank_d[i] = rank_q[i] + IDX_W'(1);
				end
			end
			if (!full) begin
				occ_d = occ_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (key_we[i]) begin
				key_q[i] <= req_s1.lookup_key;
			end
			if (val_we[i]) begin
				val_q[i] <= req_s1.store_value;
			end
		end
	end

	// result register
	logic done_s2;
	rsp_t rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1 && (req_s1.cmd == CMD_GET);
		end
	end

	always_ff @(posedge clk) begin
		rsp_s2.hit        <= hit_any;
		rsp_s2.read_value <= hit_any ? hit_val : '0;
	end

	assign done = done_s2;
	assign rsp  = rsp_s2;

	`LKV_ASSERT_NEXT(a_get_answers, valid_s1 && (req_s1.cmd == CMD_GET), done, "get lost its beat")
	`LKV_ASSERT_NEXT(a_set_silent, valid_s1 && (req_s1.cmd == CMD_SET), !done, "set produced a beat")
	`LKV_ASSERT_NOW(a_occ_matches, 1'b1, $countones(valid_q) == int'(occ_q), "count out of sync")
	`LKV_ASSERT_NOW(a_miss_zero, done && !rsp.hit, rsp.read_value == '0, "miss with nonzero value")
	`LKV_ASSERT_NEXT(a_fill_grows, do_insert && !full, occ_q == $past(occ_q) + CNT_W'(1), "fill did not count")

endmodule
`default_nettype wire

@@ tb/tb_lru_key_value_cache_top.sv @@
// Self-checking testbench for the LRU key-value cache against a shadow LRU store.
module tb_lru_key_value_cache_top;
	import lkv_pkg::*;

	localparam int SLOTS      = ENTRIES_DEFAULT;
	localparam int SETTLE     = 4;
	localparam int STALL_MAX  = 2000;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 145;
	localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_ENTRY_LIMIT, 2'b00};

	// Shadow LRU store; queues the get results it predicts.
	class lru_mirror;
		logic              slot_valid [SLOTS];
		logic [DATA_W-1:0] slot_key   [SLOTS];
		logic [DATA_W-1:0] slot_value [SLOTS];
		int                slot_age   [SLOTS];
		int                occupied;
		logic [LIMIT_W-1:0] limit_reg;
		rsp_t              pending_reads [$];
		int                errors;

		function new();
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_age[i]   = 0;
			end
			occupied  = 0;
			limit_reg = LIMIT_RESET;
			errors    = 0;
		endfunction

		function void touch(int s);
			foreach (slot_valid[i])
				if (i != s && slot_valid[i] && slot_age[i] < slot_age[s])
					slot_age[i]++;
			slot_age[s] = 0;
		endfunction

		function void insert(int s, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
			foreach (slot_valid[i])
				if (slot_valid[i])
					slot_age[i]++;
			slot_valid[s] = 1'b1;
			slot_key[s]   = k;
			slot_value[s] = v;
			slot_age[s]   = 0;
			occupied++;
		endfunction

		function void note_request(req_t r);
			int   hit_slot;
			int   victim;
			int   cap;
			rsp_t res;
			hit_slot = -1;
			foreach (slot_valid[i])
				if (hit_slot < 0 && slot_valid[i] && slot_key[i] == r.lookup_key)
					hit_slot = i;
			if (r.cmd == CMD_GET) begin
				res.hit        = (hit_slot >= 0);
				res.read_value = '0;
				if (hit_slot >= 0) begin
					res.read_value = slot_value[hit_slot];
					touch(hit_slot);
				end
				pending_reads.push_back(res);
				return;
			end
			if (hit_slot >= 0) begin
				slot_value[hit_slot] = r.store_value;
				touch(hit_slot);
				return;
			end
			cap = (limit_reg == 0) ? 1 : (limit_reg > SLOTS) ? SLOTS : int'(limit_reg);
			if (occupied >= cap) begin
				victim = -1;
				foreach (slot_valid[i])
					if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				slot_valid[victim] = 1'b0;
				occupied--;
				insert(victim, r.lookup_key, r.store_value);
				return;
			end
			foreach (slot_valid[i])
				if (!slot_valid[i]) begin
					insert(i, r.lookup_key, r.store_value);
					return;
				end
		endfunction

		function void check_read(rsp_t got);
			rsp_t want;
			if (pending_reads.size() == 0) begin
				$error("unexpected result beat: hit %0d read_value %0d", got.hit, got.read_value);
				errors++;
				return;
			end
			want = pending_reads.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got.hit);
				errors++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
				errors++;
			end
		endfunction
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	req_t              req     = '0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [31:0]       pwdata  = '0;
	logic              busy;
	logic              done;
	rsp_t              rsp;
	logic [31:0]       prdata;
	logic              pready;

	lru_mirror mirror = new();
	int        stall_cycles = 0;

	lru_key_value_cache_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result check before request note: a beat at this edge belongs to an older get.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_read(rsp);
			if (start && !busy)
				mirror.note_request(req);
			if (done || (start && !busy) || (psel && penable && pready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_request(input logic c, input logic [31:0] k, input logic [31:0] v);
		req_t r;
		r.cmd         = c;
		r.lookup_key  = k;
		r.store_value = v;
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic rest(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain_reads();
		start <= 1'b0;
		while (mirror.pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write entry_limit once the store is quiet, then read it back.
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		drain_reads();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= {{(32-LIMIT_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mirror.limit_reg = v;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(32-LIMIT_W){1'b0}}, v}) begin
			$error("entry_limit: expected %0d, actual %0d", v, prdata);
			mirror.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limits [PHASES];
		logic [31:0]        pool [24];
		int                 pool_size;
		int                 cap;
		bit                 gappy;
		logic [31:0]        k;
		logic               c;

		phase_limits = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd5, 5'd17, 5'd8, 5'd3, 5'd12,
			5'd16, 5'd0};
		phase_limits[PHASES-1] = LIMIT_W'($urandom_range(0, 31));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, key/value extremes, stored -1 and 0, updates, limit corners.
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_request(CMD_SET, 32'h7fff_ffff, 32'h8000_0000);
		send_request(CMD_SET, 32'hffff_ffff, 32'hffff_ffff);
		send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
		send_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
		send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(CMD_SET, 32'h0000_0000, 32'h5a5a_5a5a);
		send_request(CMD_GET, 32'h0000_0000, 32'hffff_ffff);
		// limit below occupancy: each new key evicts one entry
		write_limit(5'd2);
		send_request(CMD_SET, 32'h0000_0001, 32'h0000_0001);
		send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);
		send_request(CMD_SET, 32'h0000_0002, 32'h0000_0002);
		send_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
		write_limit(5'd0);
		send_request(CMD_SET, 32'h5555_5555, 32'haaaa_aaaa);
		send_request(CMD_GET, 32'h5555_5555, 32'h0000_0000);
		write_limit(5'd31);
		send_request(CMD_SET, 32'haaaa_aaaa, 32'h5555_5555);
		send_request(CMD_GET, 32'haaaa_aaaa, 32'h0000_0000);

		// Random phases: keys mostly from a small pool so hits and evictions are frequent.
		for (int p = 0; p < PHASES; p++) begin
			write_limit(phase_limits[p]);
			cap = (phase_limits[p] == 0) ? 1 :
				(phase_limits[p] > SLOTS) ? SLOTS : int'(phase_limits[p]);
			pool_size = cap + $urandom_range(1, 4);
			for (int i = 0; i < pool_size; i++)
				pool[i] = $urandom();
			gappy = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (gappy && $urandom_range(0, 4) == 0)
					rest($urandom_range(1, 18));
				k = ($urandom_range(0, 15) == 0) ? $urandom() : pool[$urandom_range(0, pool_size - 1)];
				c = ($urandom_range(0, 9) < 4) ? CMD_SET : CMD_GET;
				send_request(c, k, $urandom());
			end
		end

		drain_reads();
		repeat (SETTLE) @(posedge clk);
		if (mirror.pending_reads.size() != 0) begin
			$error("%0d expected result beats never arrived", mirror.pending_reads.size());
			mirror.errors++;
		end
		if (mirror.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
